>>> hw/rtl/wsfr_pkg.sv
`default_nettype none
package wsfr_pkg;

    localparam int LengthBitsDefault = 24;
    localparam int CfgWidth = 24;
    localparam int IdxWidth = 1;

    localparam logic [23:0] MaxFrameReset = 24'd65536;
    localparam logic [23:0] MaxMessageReset = 24'd1048576;

    localparam logic [IdxWidth-1:0] RegMaxFrame = 1'b0;
    localparam logic [IdxWidth-1:0] RegMaxMessage = 1'b1;

    localparam logic [3:0] OpCont = 4'h0;
    localparam logic [3:0] OpText = 4'h1;
    localparam logic [3:0] OpBinary = 4'h2;
    localparam logic [3:0] OpClose = 4'h8;
    localparam logic [3:0] OpPing = 4'h9;
    localparam logic [3:0] OpPong = 4'hA;

    localparam logic [1:0] EvPayload = 2'd0;
    localparam logic [1:0] EvEmptyEnd = 2'd1;
    localparam logic [1:0] EvAbandon = 2'd2;
    localparam logic [1:0] EvClose = 2'd3;

    localparam logic [2:0] RsnNormal = 3'd0;
    localparam logic [2:0] RsnFrameBig = 3'd1;
    localparam logic [2:0] RsnBadCont = 3'd2;
    localparam logic [2:0] RsnMsgBig = 3'd3;
    localparam logic [2:0] RsnBadOp = 3'd4;

    typedef enum logic [2:0] {
        PH_HDR0 = 3'd0,
        PH_HDR1 = 3'd1,
        PH_EXT  = 3'd2,
        PH_MASK = 3'd3,
        PH_PAY  = 3'd4
    } phase_t;

    // One result as it travels through the queue.
    typedef struct packed {
        logic [1:0] event_res;
        logic [7:0] payload_byte;
        logic       frame_kind;
        logic       message_type;
        logic       frame_last;
        logic       message_last;
        logic [2:0] close_reason;
        logic       run_last;
    } result_t;

    localparam int ResultWidth = $bits(result_t);

endpackage
`default_nettype wire

>>> hw/rtl/wsfr_parser.sv
`default_nettype none
module wsfr_parser #(
    parameter int LENGTH_BITS = wsfr_pkg::LengthBitsDefault
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     cfg_we,
    input  wire logic                     cfg_idx,
    input  wire logic [23:0]              cfg_data,
    input  wire logic                     in_valid,
    output logic                          in_ready,
    input  wire logic [7:0]               rx_byte,
    output logic                          res_we,
    output logic                          res_two,
    output wsfr_pkg::result_t             res_a,
    output wsfr_pkg::result_t             res_b,
    input  wire logic                     q_room
);
    import wsfr_pkg::*;

    localparam int LB = LENGTH_BITS;

    logic [23:0]   max_frame_reg;
    logic [23:0]   max_msg_reg;
    phase_t        phase_reg, phase_next;
    logic          final_reg, final_next;
    logic [3:0]    opcode_reg, opcode_next;
    logic          masked_reg, masked_next;
    logic [3:0]    left_reg, left_next;
    logic [LB-1:0] acc_reg, acc_next;
    logic          acc_ovf_reg, acc_ovf_next;
    logic [31:0]   key_reg, key_next;
    logic [LB-1:0] pay_reg, pay_next;
    logic [1:0]    midx_reg, midx_next;
    logic          mopen_reg, mopen_next;
    logic          mkind_reg, mkind_next;
    logic [LB-1:0] mlen_reg, mlen_next;
    logic          closed_reg, closed_next;

    logic [LB-1:0] lim_frame, lim_msg;
    logic          go;
    logic [LB-1:0] hdr_len;
    logic          hdr_ovf;
    logic          len_done, begin_pay;
    logic [LB-1:0] frame_len;
    logic [LB:0]   msg_sum;
    logic [7:0]    unmasked;
    logic          last_byte;
    logic [LB-1:0] pay_dec;
    logic [LB-1:0] cur_mlen;
    logic          cur_mopen, cur_mkind;
    result_t       r0, r1;
    logic          n0, n1;

    // Limits clamped to the counter width.
    always_comb
    begin
        if (LB >= 24)
        begin
            lim_frame = LB'(max_frame_reg);
            lim_msg   = LB'(max_msg_reg);
        end
        else
        begin
            lim_frame = (|(max_frame_reg >> LB)) ? '1 : LB'(max_frame_reg);
            lim_msg   = (|(max_msg_reg >> LB)) ? '1 : LB'(max_msg_reg);
        end
    end

    assign in_ready = q_room;
    assign go = in_valid && q_room;
    assign unmasked = rx_byte ^ key_reg[8*(3-midx_reg) +: 8];
    assign pay_dec = pay_reg - LB'(1);
    assign last_byte = (pay_dec == '0);

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_frame_reg <= MaxFrameReset;
            max_msg_reg   <= MaxMessageReset;
        end
        else if (cfg_we)
        begin
            if (cfg_idx == RegMaxFrame)
                max_frame_reg <= cfg_data;
            else
                max_msg_reg <= cfg_data;
        end
    end

    // Parser step: one byte, at most two results.
    always_comb
    begin
        phase_next   = phase_reg;
        final_next   = final_reg;
        opcode_next  = opcode_reg;
        masked_next  = masked_reg;
        left_next    = left_reg;
        acc_next     = acc_reg;
        acc_ovf_next = acc_ovf_reg;
        key_next     = key_reg;
        pay_next     = pay_reg;
        midx_next    = midx_reg;
        mopen_next   = mopen_reg;
        mkind_next   = mkind_reg;
        mlen_next    = mlen_reg;
        closed_next  = closed_reg;
        r0 = '0;
        r1 = '0;
        n0 = 1'b0;
        n1 = 1'b0;
        len_done  = 1'b0;
        begin_pay = 1'b0;
        hdr_len   = acc_reg;
        hdr_ovf   = acc_ovf_reg;
        frame_len = pay_reg;
        cur_mopen = mopen_reg;
        cur_mkind = mkind_reg;
        cur_mlen  = mlen_reg;
        msg_sum   = '0;

        if (go && !closed_reg)
        begin
            unique case (phase_reg)
                PH_HDR1:
                begin
                    masked_next  = rx_byte[7];
                    acc_next     = '0;
                    acc_ovf_next = 1'b0;
                    if (rx_byte[6:0] == 7'd126)
                    begin
                        left_next  = 4'd2;
                        phase_next = PH_EXT;
                    end
                    else if (rx_byte[6:0] == 7'd127)
                    begin
                        left_next  = 4'd8;
                        phase_next = PH_EXT;
                    end
                    else
                    begin
                        hdr_len  = LB'(rx_byte[6:0]);
                        hdr_ovf  = 1'b0;
                        len_done = 1'b1;
                    end
                end
                PH_EXT:
                begin
                    hdr_len = {acc_reg[LB-9:0], rx_byte};
                    hdr_ovf = acc_ovf_reg || (|acc_reg[LB-1:LB-8]);
                    acc_next     = hdr_len;
                    acc_ovf_next = hdr_ovf;
                    left_next = left_reg - 4'd1;
                    len_done  = (left_reg == 4'd1);
                end
                PH_MASK:
                begin
                    key_next  = {key_reg[23:0], rx_byte};
                    left_next = left_reg - 4'd1;
                    begin_pay = (left_reg == 4'd1);
                end
                PH_PAY:
                begin
                    midx_next = midx_reg + 2'd1;
                    pay_next  = pay_dec;
                    if (opcode_reg == OpPing)
                    begin
                        n0 = 1'b1;
                        r0.event_res = EvPayload;
                        r0.payload_byte = unmasked;
                        r0.frame_kind = 1'b1;
                        r0.frame_last = last_byte;
                        if (last_byte)
                            phase_next = PH_HDR0;
                    end
                    else if (opcode_reg == OpPong)
                    begin
                        if (last_byte)
                            phase_next = PH_HDR0;
                    end
                    else
                    begin
                        n0 = 1'b1;
                        r0.event_res = EvPayload;
                        r0.payload_byte = unmasked;
                        r0.message_type = mkind_reg;
                        r0.frame_last = last_byte;
                        r0.message_last = last_byte && final_reg;
                        if (last_byte)
                        begin
                            phase_next = PH_HDR0;
                            if (final_reg)
                            begin
                                mopen_next = 1'b0;
                                mlen_next  = '0;
                            end
                        end
                    end
                end
                default:
                begin
                    final_next  = rx_byte[7];
                    opcode_next = rx_byte[3:0];
                    phase_next  = PH_HDR1;
                end
            endcase

            // Header length complete.
            if (len_done)
            begin
                if (hdr_ovf || hdr_len > lim_frame)
                begin
                    n0 = 1'b1;
                    r0.event_res = EvClose;
                    r0.close_reason = RsnFrameBig;
                    closed_next = 1'b1;
                    mopen_next  = 1'b0;
                    mlen_next   = '0;
                    phase_next  = PH_HDR0;
                end
                else
                begin
                    pay_next  = hdr_len;
                    frame_len = hdr_len;
                    key_next  = '0;
                    if (masked_next)
                    begin
                        left_next  = 4'd4;
                        phase_next = PH_MASK;
                    end
                    else
                        begin_pay = 1'b1;
                end
            end

            // Payload start decisions.
            if (begin_pay)
            begin
                midx_next = 2'd0;
                if (opcode_reg == OpText || opcode_reg == OpBinary)
                begin
                    if (mopen_reg)
                    begin
                        n0 = 1'b1;
                        r0.event_res = EvAbandon;
                        r0.message_type = mkind_reg;
                    end
                    cur_mopen = 1'b1;
                    cur_mkind = (opcode_reg == OpBinary);
                    cur_mlen  = '0;
                end
                if (opcode_reg == OpText || opcode_reg == OpBinary
                    || opcode_reg == OpCont)
                begin
                    msg_sum = {1'b0, cur_mlen} + {1'b0, frame_len};
                    mkind_next = cur_mkind;
                    if (!cur_mopen || msg_sum > {1'b0, lim_msg})
                    begin
                        n1 = 1'b1;
                        r1.event_res = EvClose;
                        r1.close_reason = cur_mopen ? RsnMsgBig : RsnBadCont;
                        closed_next = 1'b1;
                        mopen_next  = 1'b0;
                        mlen_next   = '0;
                        phase_next  = PH_HDR0;
                    end
                    else if (frame_len == '0)
                    begin
                        n1 = 1'b1;
                        r1.event_res = EvEmptyEnd;
                        r1.message_type = cur_mkind;
                        r1.frame_last = 1'b1;
                        r1.message_last = final_reg;
                        phase_next = PH_HDR0;
                        mopen_next = !final_reg;
                        mlen_next  = final_reg ? '0 : msg_sum[LB-1:0];
                    end
                    else
                    begin
                        mopen_next = 1'b1;
                        mlen_next  = msg_sum[LB-1:0];
                        phase_next = PH_PAY;
                    end
                end
                else if (opcode_reg == OpClose)
                begin
                    n1 = 1'b1;
                    r1.event_res = EvClose;
                    r1.close_reason = RsnNormal;
                    closed_next = 1'b1;
                    mopen_next  = 1'b0;
                    mlen_next   = '0;
                    phase_next  = PH_HDR0;
                end
                else if (opcode_reg == OpPing)
                begin
                    if (frame_len == '0)
                    begin
                        n1 = 1'b1;
                        r1.event_res = EvEmptyEnd;
                        r1.frame_kind = 1'b1;
                        r1.frame_last = 1'b1;
                        phase_next = PH_HDR0;
                    end
                    else
                        phase_next = PH_PAY;
                end
                else if (opcode_reg == OpPong)
                    phase_next = (frame_len == '0) ? PH_HDR0 : PH_PAY;
                else
                begin
                    n1 = 1'b1;
                    r1.event_res = EvClose;
                    r1.close_reason = RsnBadOp;
                    closed_next = 1'b1;
                    mopen_next  = 1'b0;
                    mlen_next   = '0;
                    phase_next  = PH_HDR0;
                end
            end
        end
    end

    // Pack the results: first slot always holds the earliest one.
    always_comb
    begin
        res_we  = n0 || n1;
        res_two = n0 && n1;
        if (n0)
        begin
            res_a = r0;
            res_b = r1;
            res_b.run_last = 1'b1;
            res_a.run_last = !n1;
        end
        else
        begin
            res_a = r1;
            res_a.run_last = 1'b1;
            res_b = r1;
        end
    end

    // Parser state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_HDR0;
            final_reg   <= 1'b0;
            opcode_reg  <= '0;
            masked_reg  <= 1'b0;
            left_reg    <= '0;
            acc_reg     <= '0;
            acc_ovf_reg <= 1'b0;
            key_reg     <= '0;
            pay_reg     <= '0;
            midx_reg    <= '0;
            mopen_reg   <= 1'b0;
            mkind_reg   <= 1'b0;
            mlen_reg    <= '0;
            closed_reg  <= 1'b0;
        end
        else
        begin
            phase_reg   <= phase_next;
            final_reg   <= final_next;
            opcode_reg  <= opcode_next;
            masked_reg  <= masked_next;
            left_reg    <= left_next;
            acc_reg     <= acc_next;
            acc_ovf_reg <= acc_ovf_next;
            key_reg     <= key_next;
            pay_reg     <= pay_next;
            midx_reg    <= midx_next;
            mopen_reg   <= mopen_next;
            mkind_reg   <= mkind_next;
            mlen_reg    <= mlen_next;
            closed_reg  <= closed_next;
        end
    end

endmodule
`default_nettype wire

>>> hw/rtl/wsfr_queue.sv
`default_nettype none
module wsfr_queue (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               wr_en,
    input  wire logic               wr_two,
    input  wire wsfr_pkg::result_t  wr_a,
    input  wire wsfr_pkg::result_t  wr_b,
    output logic                    room,
    output logic                    m_axis_tvalid,
    input  wire logic               m_axis_tready,
    output wsfr_pkg::result_t       rd_data
);
    import wsfr_pkg::*;

    localparam int Depth = 4;

    result_t    mem_reg [Depth];
    logic [1:0] wptr_reg, rptr_reg;
    logic [2:0] cnt_reg, cnt_next;
    logic       pop;
    logic [2:0] push_n;

    // Room for a full two-result request whether or not the sink pops this cycle.
    assign room = (cnt_reg <= 3'(Depth - 2));
    assign m_axis_tvalid = (cnt_reg != 3'd0);
    assign pop = m_axis_tvalid && m_axis_tready;
    assign rd_data = mem_reg[rptr_reg];
    assign push_n = !wr_en ? 3'd0 : (wr_two ? 3'd2 : 3'd1);
    assign cnt_next = cnt_reg + push_n - {2'b0, pop};

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wptr_reg] <= wr_a;
            if (wr_two)
                mem_reg[wptr_reg + 2'd1] <= wr_b;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            wptr_reg <= wptr_reg + push_n[1:0];
            rptr_reg <= rptr_reg + {1'b0, pop};
            cnt_reg  <= cnt_next;
        end
    end

endmodule
`default_nettype wire

>>> hw/rtl/websocket_frame_receiver_unit.sv
`default_nettype none
// WebSocket frame receiver: takes one received byte per cycle on the slave stream and
// parses frame headers, strips masking and reports payload bytes, empty frame ends,
// abandoned messages and connection close on the master stream. The front parser
// takes a byte every cycle while the four-entry result queue has room for two
// results, so throughput is one byte per cycle when the sink keeps up; results are
// registered in the queue. After a close all input is drained and ignored until reset.
// The user must write limits via the cfg port while idle; the block does not enforce it.
module websocket_frame_receiver_unit #(
    parameter int LENGTH_BITS = wsfr_pkg::LengthBitsDefault
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic        cfg_idx,
    input  wire logic [23:0] cfg_data,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // rx_byte
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // event_res[1:0], payload_byte[9:2], close_reason[12:10], zero fill [15:13]
    output logic [15:0]      m_axis_tdata,
    // frame_kind[0], message_type[1], frame_last[2], message_last[3]
    output logic [3:0]       m_axis_tuser,
    output logic             m_axis_tlast    // run_last
);
    import wsfr_pkg::*;

    logic    res_we, res_two, q_room;
    result_t res_a, res_b, rd;

    wsfr_parser #(.LENGTH_BITS(LENGTH_BITS)) u_parser (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
        .in_valid(s_axis_tvalid), .in_ready(s_axis_tready), .rx_byte(s_axis_tdata),
        .res_we(res_we), .res_two(res_two), .res_a(res_a), .res_b(res_b),
        .q_room(q_room)
    );

    wsfr_queue u_queue (
        .clk(clk), .rst_n(rst_n),
        .wr_en(res_we), .wr_two(res_two), .wr_a(res_a), .wr_b(res_b),
        .room(q_room), .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .rd_data(rd)
    );

    assign m_axis_tdata = {3'b000, rd.close_reason, rd.payload_byte, rd.event_res};
    assign m_axis_tuser = {rd.message_last, rd.frame_last, rd.message_type, rd.frame_kind};
    assign m_axis_tlast = rd.run_last;

    // A two-result request always ends its run on the second slot.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_two |-> (res_b.run_last && !res_a.run_last))
        else $error("two-result request has wrong run marks");

    // Results are only produced for an accepted byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_we |-> (s_axis_tvalid && s_axis_tready))
        else $error("result without accepted byte");

    // A close event always ends the run.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && rd.event_res == EvClose) |-> rd.run_last)
        else $error("close event not last of run");

endmodule
`default_nettype wire

>>> dv/websocket_frame_receiver_unit_tb.sv
`default_nettype none
module websocket_frame_receiver_unit_tb;
    import wsfr_pkg::*;

    localparam int CycleLimit = 400000;

    typedef enum int { ROW_NONE, ROW_PRED, ROW_ONE } row_mode_t;

    typedef struct {
        logic [7:0] rxb;
        row_mode_t  mode;
        result_t    res;
    } dir_row_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic        cfg_idx;
    logic [23:0] cfg_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;
    logic [3:0]  m_axis_tuser;
    logic        m_axis_tlast;

    // Deframer model state.
    phase_t      pm_phase;
    logic        pm_fin;
    logic [3:0]  pm_op;
    logic        pm_masked;
    logic [3:0]  pm_ext_left;
    logic [63:0] pm_len_acc;
    logic [31:0] pm_key;
    logic [23:0] pm_pay_left;
    logic [1:0]  pm_key_idx;
    logic        pm_msg_open;
    logic        pm_msg_kind;
    logic [23:0] pm_msg_len;
    logic        pm_closed;
    logic [23:0] lim_frame;
    logic [23:0] lim_msg;

    result_t     step_results[$];
    result_t     pending_results[$];
    int          errors;
    int          cycle;
    int          hold_until;
    int          send_pct;
    int          recv_pct;
    int          bytes_sent;
    dir_row_t    dir_rows[25];

    websocket_frame_receiver_unit i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_idx       (cfg_idx),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #4 clk = ~clk;
        end
    end

    function automatic result_t mk_result(logic [1:0] ev, logic [7:0] pb, logic kind,
                                          logic mtype, logic flast, logic mlast,
                                          logic [2:0] reason);
        result_t r;
        r.event_res    = ev;
        r.payload_byte = pb;
        r.frame_kind   = kind;
        r.message_type = mtype;
        r.frame_last   = flast;
        r.message_last = mlast;
        r.close_reason = reason;
        r.run_last     = 1'b1;
        return r;
    endfunction

    function automatic void add_result(logic [1:0] ev, logic [7:0] pb, logic kind,
                                       logic mtype, logic flast, logic mlast,
                                       logic [2:0] reason);
        result_t r;
        r = mk_result(ev, pb, kind, mtype, flast, mlast, reason);
        r.run_last = 1'b0;
        step_results.push_back(r);
    endfunction

    function automatic void deframer_reset();
        pm_phase    = PH_HDR0;
        pm_fin      = 1'b0;
        pm_op       = 4'h0;
        pm_masked   = 1'b0;
        pm_ext_left = 4'd0;
        pm_len_acc  = 64'd0;
        pm_key      = 32'd0;
        pm_pay_left = 24'd0;
        pm_key_idx  = 2'd0;
        pm_msg_open = 1'b0;
        pm_msg_kind = 1'b0;
        pm_msg_len  = 24'd0;
        pm_closed   = 1'b0;
        lim_frame   = MaxFrameReset;
        lim_msg     = MaxMessageReset;
    endfunction

    function automatic void shut_down(logic [2:0] reason);
        add_result(EvClose, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0, reason);
        pm_closed   = 1'b1;
        pm_msg_open = 1'b0;
        pm_msg_len  = 24'd0;
        pm_phase    = PH_HDR0;
    endfunction

    function automatic void finish_data_frame();
        if (pm_fin)
        begin
            pm_msg_open = 1'b0;
            pm_msg_len  = 24'd0;
        end
        pm_phase = PH_HDR0;
    endfunction

    // Header fully known: decide what the frame does.
    function automatic void open_payload();
        logic is_data;
        is_data = 1'b0;
        pm_key_idx = 2'd0;
        case (pm_op)
            OpText, OpBinary:
            begin
                if (pm_msg_open)
                    add_result(EvAbandon, 8'h00, 1'b0, pm_msg_kind, 1'b0, 1'b0, RsnNormal);
                pm_msg_open = 1'b1;
                pm_msg_kind = (pm_op == OpBinary);
                pm_msg_len  = 24'd0;
                is_data = 1'b1;
            end
            OpCont: is_data = 1'b1;
            OpClose: shut_down(RsnNormal);
            OpPing:
            begin
                if (pm_pay_left == 24'd0)
                begin
                    add_result(EvEmptyEnd, 8'h00, 1'b1, 1'b0, 1'b1, 1'b0, RsnNormal);
                    pm_phase = PH_HDR0;
                end
                else
                    pm_phase = PH_PAY;
            end
            OpPong: pm_phase = (pm_pay_left == 24'd0) ? PH_HDR0 : PH_PAY;
            default: shut_down(RsnBadOp);
        endcase
        if (is_data)
        begin
            if (!pm_msg_open)
                shut_down(RsnBadCont);
            else if ({40'd0, pm_msg_len} + {40'd0, pm_pay_left} > {40'd0, lim_msg})
                shut_down(RsnMsgBig);
            else
            begin
                pm_msg_len = pm_msg_len + pm_pay_left;
                if (pm_pay_left == 24'd0)
                begin
                    add_result(EvEmptyEnd, 8'h00, 1'b0, pm_msg_kind, 1'b1, pm_fin,
                               RsnNormal);
                    finish_data_frame();
                end
                else
                    pm_phase = PH_PAY;
            end
        end
    endfunction

    function automatic void length_known();
        if (pm_len_acc > {40'd0, lim_frame})
            shut_down(RsnFrameBig);
        else
        begin
            pm_pay_left = pm_len_acc[23:0];
            pm_key = 32'd0;
            if (pm_masked)
            begin
                pm_ext_left = 4'd4;
                pm_phase = PH_MASK;
            end
            else
                open_payload();
        end
    endfunction

    // Advance the deframer by one received byte; results land in step_results.
    function automatic void deframe_byte(logic [7:0] rxb);
        logic [7:0] plain;
        logic       last;
        step_results.delete();
        if (!pm_closed)
        begin
            case (pm_phase)
                PH_HDR1:
                begin
                    pm_masked  = rxb[7];
                    pm_len_acc = 64'd0;
                    if (rxb[6:0] == 7'd126)
                    begin
                        pm_ext_left = 4'd2;
                        pm_phase = PH_EXT;
                    end
                    else if (rxb[6:0] == 7'd127)
                    begin
                        pm_ext_left = 4'd8;
                        pm_phase = PH_EXT;
                    end
                    else
                    begin
                        pm_len_acc = {57'd0, rxb[6:0]};
                        length_known();
                    end
                end
                PH_EXT:
                begin
                    pm_len_acc = {pm_len_acc[55:0], rxb};
                    pm_ext_left = pm_ext_left - 4'd1;
                    if (pm_ext_left == 4'd0)
                        length_known();
                end
                PH_MASK:
                begin
                    pm_key = {pm_key[23:0], rxb};
                    pm_ext_left = pm_ext_left - 4'd1;
                    if (pm_ext_left == 4'd0)
                        open_payload();
                end
                PH_PAY:
                begin
                    plain = rxb ^ pm_key[(3 - pm_key_idx) * 8 +: 8];
                    pm_key_idx = pm_key_idx + 2'd1;
                    pm_pay_left = pm_pay_left - 24'd1;
                    last = (pm_pay_left == 24'd0);
                    if (pm_op == OpPing)
                    begin
                        add_result(EvPayload, plain, 1'b1, 1'b0, last, 1'b0, RsnNormal);
                        if (last)
                            pm_phase = PH_HDR0;
                    end
                    else if (pm_op == OpPong)
                    begin
                        if (last)
                            pm_phase = PH_HDR0;
                    end
                    else
                    begin
                        add_result(EvPayload, plain, 1'b0, pm_msg_kind, last,
                                   last & pm_fin, RsnNormal);
                        if (last)
                            finish_data_frame();
                    end
                end
                default:
                begin
                    pm_fin = rxb[7];
                    pm_op = rxb[3:0];
                    pm_phase = PH_HDR1;
                end
            endcase
        end
        if (step_results.size() > 0)
            step_results[step_results.size() - 1].run_last = 1'b1;
    endfunction

    // Offer one byte, wait for acceptance, then record what it should produce.
    task automatic send_byte(logic [7:0] rxb, row_mode_t mode, result_t typed);
        while ($urandom_range(99) < send_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= rxb;
        do
            @(posedge clk);
        while (!(s_axis_tvalid && s_axis_tready));
        bytes_sent++;
        deframe_byte(rxb);
        if (mode == ROW_ONE)
            pending_results.push_back(typed);
        else
            foreach (step_results[i])
                pending_results.push_back(step_results[i]);
    endtask

    task automatic send_rand(logic [7:0] rxb);
        send_byte(rxb, ROW_PRED, '0);
    endtask

    // Stop sending and let every expected result and any trailing work finish.
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    // One register write, after which the write enable is dropped again.
    task automatic write_limit(logic idx, logic [23:0] value);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == RegMaxFrame)
            lim_frame = value;
        else
            lim_msg = value;
        @(posedge clk);
    endtask

    // One well-formed frame with random content that stays within the limits.
    task automatic send_random_frame();
        int         pick;
        int         cap;
        int         len;
        int         enc;
        logic [3:0] op;
        logic       fin;
        logic       masked;
        logic [31:0] key;
        logic [63:0] len64;
        pick = $urandom_range(99);
        cap = int'(lim_frame);
        if (pick < 15)
            op = OpPing;
        else if (pick < 25)
            op = OpPong;
        else if (!pm_msg_open || pm_msg_len > lim_msg || $urandom_range(9) == 0)
        begin
            op = $urandom_range(1) ? OpBinary : OpText;
            if (lim_msg < cap)
                cap = int'(lim_msg);
        end
        else
        begin
            op = OpCont;
            if (lim_msg - pm_msg_len < cap)
                cap = int'(lim_msg - pm_msg_len);
        end
        if ($urandom_range(11) == 0)
            len = (cap < 140) ? cap : 140;
        else
            len = $urandom_range(0, (cap < 12) ? cap : 12);
        fin = (op == OpPing || op == OpPong) ? 1'($urandom_range(1))
                                             : ($urandom_range(9) < 7);
        masked = 1'($urandom_range(1));
        key = $urandom;
        len64 = 64'(len);
        enc = (len > 125) ? $urandom_range(1, 2) : $urandom_range(2);
        send_rand({fin, 3'($urandom_range(7)), op});
        if (enc == 0)
            send_rand({masked, len64[6:0]});
        else if (enc == 1)
        begin
            send_rand({masked, 7'd126});
            for (int i = 1; i >= 0; i--)
                send_rand(len64[i * 8 +: 8]);
        end
        else
        begin
            send_rand({masked, 7'd127});
            for (int i = 7; i >= 0; i--)
                send_rand(len64[i * 8 +: 8]);
        end
        if (masked)
            for (int i = 3; i >= 0; i--)
                send_rand(key[i * 8 +: 8]);
        for (int i = 0; i < len; i++)
            send_rand(8'($urandom));
    endtask

    // Cycle count and run limit.
    always @(posedge clk)
    begin
        cycle <= cycle + 1;
        if (cycle == CycleLimit)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Result sink with random stalls and one long hold-off.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else if (cycle < hold_until)
            m_axis_tready <= 1'b0;
        else
            m_axis_tready <= ($urandom_range(99) >= recv_pct);
    end

    // Compare each delivered result with the oldest expectation.
    always @(posedge clk)
    begin
        result_t got;
        result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = mk_result(m_axis_tdata[1:0], m_axis_tdata[9:2], m_axis_tuser[0],
                            m_axis_tuser[1], m_axis_tuser[2], m_axis_tuser[3],
                            m_axis_tdata[12:10]);
            got.run_last = m_axis_tlast;
            if (pending_results.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result %h", $time, got);
            end
            else
            begin
                want = pending_results.pop_front();
                if (got !== want)
                begin
                    errors++;
                    $display("%0t: result mismatch expected %h actual %h", $time, want, got);
                end
            end
        end
    end

    initial
    begin
        int         reason;
        int         start_count;
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_idx       = RegMaxFrame;
        cfg_data      = 24'd0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = 8'd0;
        errors        = 0;
        cycle         = 0;
        hold_until    = 0;
        send_pct      = 0;
        recv_pct      = 0;
        bytes_sent    = 0;
        deframer_reset();

        // Masked text frame, empty text frame, open text fragment, empty unfinished ping,
        // silent pong, then a binary start that abandons the open text message.
        dir_rows = '{
            '{8'h81, ROW_NONE, '0}, '{8'h83, ROW_NONE, '0},
            '{8'hFF, ROW_NONE, '0}, '{8'h00, ROW_NONE, '0},
            '{8'hA5, ROW_NONE, '0}, '{8'h5A, ROW_NONE, '0},
            '{8'h00, ROW_PRED, '0}, '{8'hFF, ROW_PRED, '0}, '{8'h12, ROW_PRED, '0},
            '{8'h81, ROW_NONE, '0},
            '{8'h00, ROW_ONE, mk_result(EvEmptyEnd, 8'h00, 1'b0, 1'b0, 1'b1, 1'b1,
                                        RsnNormal)},
            '{8'h01, ROW_NONE, '0}, '{8'h01, ROW_NONE, '0}, '{8'hFF, ROW_PRED, '0},
            '{8'h09, ROW_NONE, '0}, '{8'h80, ROW_NONE, '0},
            '{8'h00, ROW_NONE, '0}, '{8'h00, ROW_NONE, '0}, '{8'h00, ROW_NONE, '0},
            '{8'h00, ROW_ONE, mk_result(EvEmptyEnd, 8'h00, 1'b1, 1'b0, 1'b1, 1'b0,
                                        RsnNormal)},
            '{8'h8A, ROW_NONE, '0}, '{8'h01, ROW_NONE, '0}, '{8'h55, ROW_NONE, '0},
            '{8'h82, ROW_NONE, '0}, '{8'h00, ROW_PRED, '0}
        };

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
            send_byte(dir_rows[i].rxb, dir_rows[i].mode, dir_rows[i].res);

        // Random phases, each with its own limits and idling pattern.
        for (int ph = 0; ph < 4; ph++)
        begin
            wait_idle();
            case (ph)
                0:
                begin
                    write_limit(RegMaxFrame, 24'hFFFFFF);
                    write_limit(RegMaxMessage, 24'hFFFFFF);
                    send_pct = 0;
                    recv_pct = 0;
                    hold_until = cycle + 300;
                end
                1:
                begin
                    write_limit(RegMaxFrame, 24'd0);
                    write_limit(RegMaxMessage, 24'd0);
                    send_pct = 71;
                    recv_pct = 0;
                end
                2:
                begin
                    write_limit(RegMaxFrame, 24'($urandom_range(20, 60)));
                    write_limit(RegMaxMessage, 24'($urandom_range(40, 200)));
                    send_pct = 0;
                    recv_pct = 71;
                end
                default:
                begin
                    write_limit(RegMaxFrame, MaxFrameReset);
                    write_limit(RegMaxMessage, MaxMessageReset);
                    send_pct = 29;
                    recv_pct = 29;
                end
            endcase
            start_count = bytes_sent;
            while (bytes_sent < start_count + 100)
                send_random_frame();
        end

        // The connection closes only once, so one close cause is picked per run.
        wait_idle();
        reason = $urandom_range(4);
        case (reason)
            0:
            begin
                send_rand(8'h88);
                send_rand(8'h00);
            end
            1:
            begin
                send_rand(8'h82);
                send_rand(8'hFF);
                send_rand(8'($urandom) | 8'h80);
                for (int i = 0; i < 7; i++)
                    send_rand(8'($urandom));
            end
            2:
            begin
                if (pm_msg_open)
                begin
                    send_rand({1'b1, 3'b000, OpCont});
                    send_rand(8'h00);
                end
                send_rand({1'b1, 3'b000, OpCont});
                send_rand(8'h00);
            end
            3:
            begin
                write_limit(RegMaxMessage, 24'd2);
                send_rand({1'b1, 3'b000, OpText});
                send_rand(8'h05);
            end
            default:
            begin
                send_rand({1'b1, 3'b000, 4'($urandom_range(3, 7))});
                send_rand(8'h00);
            end
        endcase
        // Bytes after the close are dropped.
        for (int i = 0; i < 6; i++)
            send_rand(8'($urandom));

        wait_idle();
        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
`default_nettype wire

>>> files.f
hw/rtl/wsfr_pkg.sv
hw/rtl/wsfr_parser.sv
hw/rtl/wsfr_queue.sv
hw/rtl/websocket_frame_receiver_unit.sv
dv/websocket_frame_receiver_unit_tb.sv
